[rtl/cma_pkg.sv]
// ---------------------------------------------------------------------------
// Confusion matrix accumulator package
// Shared field widths, request and register codes, and the result word type.
// ---------------------------------------------------------------------------
package cma_pkg;

    localparam int SCORE_W     = 16;
    localparam int LABEL_W     = 4;
    localparam int OUT_COUNT_W = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 72;

    // Request kinds carried in the input tuser bit.
    localparam logic REQ_SCORE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SCORE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_SIZE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] SCORE_COUNT_RESET = 5'd10;
    localparam logic [CFG_DATA_W-1:0] MATRIX_SIZE_RESET = 5'd10;

    // 0.5 in Q1.14.
    localparam logic signed [SCORE_W-1:0] HALF_Q14 = 16'sd8192;

    typedef struct packed {
        logic                   is_readback;
        logic [LABEL_W-1:0]     chosen_class;
        logic                   is_correct;
        logic                   counted;
        logic [OUT_COUNT_W-1:0] cell_count;
        logic [OUT_COUNT_W-1:0] correct_total;
    } result_t;

endpackage

[rtl/confusion_matrix_accumulator_unit.sv]
// ---------------------------------------------------------------------------
// Confusion matrix accumulator
// Streaming argmax classifier evaluation with a saturating confusion matrix.
// ---------------------------------------------------------------------------
// The block takes one word per cycle while s_axis_tready is high: a class
// score or a cell read. Scores update a running argmax held in registers; the
// word marked last decides the prediction, and the confusion cell is then read
// from a RAM, incremented with saturation and written back in the cycle after
// the read, with the last write forwarded so that back-to-back hits on one cell
// see the fresh value. A result word is held in stage 1 and then goes through
// a three-word output queue, so a stalled output does not stop input until the
// queue is full. After reset the RAM is cleared one cell per cycle, all
// MAX_CLASSES * MAX_CLASSES cells (256 with the default), during which no
// input word is taken; configuration writes are taken at any time.
// ---------------------------------------------------------------------------
module confusion_matrix_accumulator_unit
    import cma_pkg::*;
#(
    parameter int MAX_CLASSES = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // score[15:0], actual_class[19:16], read_row[23:20], read_col[27:24], zeros
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // req_type
    input  logic                   s_axis_tuser,
    // last_score
    input  logic                   s_axis_tlast,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // chosen_class[3:0], is_correct[4], counted[5], cell_count[37:6],
    // correct_total[69:38], zeros
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // is_readback
    output logic                   m_axis_tuser
);

    localparam int DEPTH = MAX_CLASSES * MAX_CLASSES;
    localparam int AW    = $clog2(DEPTH);
    localparam int IDXW  = $clog2(MAX_CLASSES);
    localparam int POSW  = $clog2(MAX_CLASSES + 1);
    localparam int CMPW  = (POSW > CFG_DATA_W) ? POSW : CFG_DATA_W;
    localparam int MULW  = AW + LABEL_W + 1;
    localparam int QDEPTH = 3;

    // -----------------------------------------------------------------------
    // Configuration
    // -----------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] score_count_reg;
    logic [CFG_DATA_W-1:0] matrix_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_count_reg <= SCORE_COUNT_RESET;
            matrix_size_reg <= MATRIX_SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCORE_COUNT: score_count_reg <= cfg_data;
                REG_MATRIX_SIZE: matrix_size_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Input unpacking and argmax
    // -----------------------------------------------------------------------
    logic                      in_req;
    logic signed [SCORE_W-1:0] in_score;
    logic [LABEL_W-1:0]        in_label;
    logic [LABEL_W-1:0]        in_row;
    logic [LABEL_W-1:0]        in_col;
    logic                      accept;

    assign in_req   = s_axis_tuser;
    assign in_score = s_axis_tdata[SCORE_W-1:0];
    assign in_label = s_axis_tdata[SCORE_W +: LABEL_W];
    assign in_row   = s_axis_tdata[SCORE_W+LABEL_W +: LABEL_W];
    assign in_col   = s_axis_tdata[SCORE_W+2*LABEL_W +: LABEL_W];
    assign accept   = s_axis_tvalid && s_axis_tready;

    logic signed [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [IDXW-1:0]           best_index_reg, best_index_next;
    logic [POSW-1:0]           class_pos_reg, class_pos_next;

    logic signed [SCORE_W-1:0] upd_score;
    logic [IDXW-1:0]           upd_index;
    logic [POSW-1:0]           upd_pos;
    logic [IDXW-1:0]           pred;
    logic [CMPW-1:0]           eff_size;
    logic                      sample_ok;
    logic                      sample_inb;
    logic                      read_inb;
    logic [MULW-1:0]           sample_addr_w;
    logic [MULW-1:0]           read_addr_w;

    always_comb
    begin
        upd_score = best_score_reg;
        upd_index = best_index_reg;
        upd_pos   = class_pos_reg;
        if (class_pos_reg < POSW'(MAX_CLASSES))
        begin
            if (class_pos_reg == '0 || in_score > best_score_reg)
            begin
                upd_score = in_score;
                upd_index = class_pos_reg[IDXW-1:0];
            end
            upd_pos = class_pos_reg + 1'b1;
        end

        if (score_count_reg == CFG_DATA_W'(1))
        begin
            pred = (upd_score > HALF_Q14) ? IDXW'(1) : '0;
        end
        else
        begin
            pred = upd_index;
        end

        eff_size = (CMPW'(matrix_size_reg) > CMPW'(MAX_CLASSES)) ?
                   CMPW'(MAX_CLASSES) : CMPW'(matrix_size_reg);

        sample_ok  = (CMPW'(pred) == CMPW'(in_label));
        sample_inb = (CMPW'(in_label) < eff_size) && (CMPW'(pred) < eff_size);
        read_inb   = (CMPW'(in_row) < eff_size) && (CMPW'(in_col) < eff_size);

        sample_addr_w = MULW'(in_label) * MULW'(MAX_CLASSES) + MULW'(pred);
        read_addr_w   = MULW'(in_row) * MULW'(MAX_CLASSES) + MULW'(in_col);

        best_score_next = best_score_reg;
        best_index_next = best_index_reg;
        class_pos_next  = class_pos_reg;
        if (accept && in_req == REQ_SCORE)
        begin
            if (s_axis_tlast)
            begin
                best_score_next = '0;
                best_index_next = '0;
                class_pos_next  = '0;
            end
            else
            begin
                best_score_next = upd_score;
                best_index_next = upd_index;
                class_pos_next  = upd_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_index_reg <= '0;
            class_pos_reg  <= '0;
        end
        else
        begin
            best_score_reg <= best_score_next;
            best_index_reg <= best_index_next;
            class_pos_reg  <= class_pos_next;
        end
    end

    // -----------------------------------------------------------------------
    // Clearing pass and cell RAM
    // -----------------------------------------------------------------------
    logic          clear_active_reg;
    logic [AW-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == AW'(DEPTH - 1))
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // Stage 1: the word whose cell read is in flight.
    logic                   s1_res_reg;
    logic                   s1_read_reg;
    logic                   s1_inb_reg;
    logic                   s1_ok_reg;
    logic [LABEL_W-1:0]     s1_pred_reg;
    logic [AW-1:0]          s1_addr_reg;

    // Last write, kept so that a read issued at the same edge sees it.
    logic                   fwd_valid_reg;
    logic [AW-1:0]          fwd_addr_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;

    logic [AW-1:0]          ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;

    logic [COUNT_WIDTH-1:0] cell_cur;
    logic [COUNT_WIDTH-1:0] cell_new;
    logic                   s1_write;

    logic [COUNT_WIDTH-1:0] correct_count_reg, correct_count_next;

    assign ram_raddr = (in_req == REQ_READ) ? read_addr_w[AW-1:0] : sample_addr_w[AW-1:0];

    always_comb
    begin
        cell_cur = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : ram_rdata;
        cell_new = (&cell_cur) ? cell_cur : cell_cur + 1'b1;
        s1_write = s1_res_reg && !s1_read_reg && s1_inb_reg;

        ram_we    = clear_active_reg || s1_write;
        ram_waddr = clear_active_reg ? clear_addr_reg : s1_addr_reg;
        ram_wdata = clear_active_reg ? '0 : cell_new;

        correct_count_next = correct_count_reg;
        if (s1_res_reg && !s1_read_reg && s1_ok_reg && !(&correct_count_reg))
        begin
            correct_count_next = correct_count_reg + 1'b1;
        end
    end

    cma_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(DEPTH)
    ) u_cell_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_res_reg        <= 1'b0;
            fwd_valid_reg     <= 1'b0;
            correct_count_reg <= '0;
        end
        else
        begin
            s1_res_reg        <= accept && (in_req == REQ_READ || s_axis_tlast);
            fwd_valid_reg     <= s1_write;
            correct_count_reg <= correct_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_read_reg  <= (in_req == REQ_READ);
        s1_inb_reg   <= (in_req == REQ_READ) ? read_inb : sample_inb;
        s1_ok_reg    <= sample_ok;
        s1_pred_reg  <= LABEL_W'(pred);
        s1_addr_reg  <= ram_raddr;
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= cell_new;
    end

    // -----------------------------------------------------------------------
    // Result words and output queue
    // -----------------------------------------------------------------------
    result_t s1_result;

    always_comb
    begin
        s1_result.is_readback   = s1_read_reg;
        s1_result.chosen_class  = s1_read_reg ? '0 : s1_pred_reg;
        s1_result.is_correct    = !s1_read_reg && s1_ok_reg;
        s1_result.counted       = !s1_read_reg && s1_inb_reg;
        // A sample result shows the count including its own hit.
        s1_result.correct_total = OUT_COUNT_W'(correct_count_next);
        if (!s1_inb_reg)
        begin
            s1_result.cell_count = '0;
        end
        else if (s1_read_reg)
        begin
            s1_result.cell_count = OUT_COUNT_W'(cell_cur);
        end
        else
        begin
            s1_result.cell_count = OUT_COUNT_W'(cell_new);
        end
    end

    result_t    queue_reg [QDEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [1:0] count_reg;
    logic       q_push;
    logic       q_pop;
    logic [2:0] q_pending;

    assign q_push    = s1_res_reg;
    assign q_pop     = m_axis_tvalid && m_axis_tready;
    assign q_pending = 3'(count_reg) + 3'(s1_res_reg);

    // A taken word passes through stage 1 before it lands in the queue; keep room for it.
    assign s_axis_tready = !clear_active_reg && (q_pending < 3'(QDEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == 2'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == 2'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (q_push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (q_pop && !q_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            queue_reg[wr_ptr_reg] <= s1_result;
        end
    end

    result_t head;

    assign head          = queue_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tuser  = head.is_readback;
    assign m_axis_tdata  = {2'b00, head.correct_total, head.cell_count,
                            head.counted, head.is_correct, head.chosen_class};

endmodule

[rtl/cma_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module cma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sim/testbench.sv]
// ---------------------------------------------------------------------------
// Confusion matrix accumulator testbench
// Streams class scores and cell reads into the unit under several register
// settings and traffic patterns. A scoreboard predicts every result word and
// checks each one on the output stream in order.
// ---------------------------------------------------------------------------
module testbench
    import cma_pkg::*;
();

    localparam int CLASS_SLOTS = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int RANDOM_ITEMS_PER_PHASE = 85;

    // Tracks the argmax of the open sample, the confusion cells and the
    // correct count, and queues the result words they lead to.
    class confusion_tracker;
        logic [CFG_DATA_W-1:0]  score_count;
        logic [CFG_DATA_W-1:0]  matrix_size;
        logic signed [SCORE_W-1:0] lead_score;
        logic [LABEL_W-1:0]     lead_index;
        int                     position;
        logic [OUT_COUNT_W-1:0] cells [CLASS_SLOTS * CLASS_SLOTS];
        logic [OUT_COUNT_W-1:0] hits;
        result_t                due_results [$];
        int                     mismatches;

        function new();
            score_count = SCORE_COUNT_RESET;
            matrix_size = MATRIX_SIZE_RESET;
            lead_score  = '0;
            lead_index  = '0;
            position    = 0;
            hits        = '0;
            mismatches  = 0;
            foreach (cells[i])
                cells[i] = '0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == REG_SCORE_COUNT)
                score_count = value;
            else if (index == REG_MATRIX_SIZE)
                matrix_size = value;
        endfunction

        function void take_word(logic req, logic signed [SCORE_W-1:0] score,
                                logic [LABEL_W-1:0] label, logic last,
                                logic [LABEL_W-1:0] row, logic [LABEL_W-1:0] col);
            result_t          r;
            int unsigned      span;
            logic [LABEL_W-1:0] pred;
            span = (matrix_size > CLASS_SLOTS) ? CLASS_SLOTS : matrix_size;
            r = '0;
            if (req == REQ_READ) begin
                r.is_readback = 1'b1;
                if (row < span && col < span)
                    r.cell_count = cells[{row, col}];
                r.correct_total = hits;
                due_results.push_back(r);
                return;
            end
            // Scores past the last class slot do not take part in the argmax.
            if (position < CLASS_SLOTS) begin
                if (position == 0 || score > lead_score) begin
                    lead_score = score;
                    lead_index = LABEL_W'(position);
                end
                position++;
            end
            if (!last)
                return;
            if (score_count == 1)
                pred = (lead_score > HALF_Q14) ? LABEL_W'(1) : '0;
            else
                pred = lead_index;
            r.chosen_class = pred;
            r.is_correct = (pred == label);
            if (r.is_correct && hits != '1)
                hits++;
            if (label < span && pred < span) begin
                r.counted = 1'b1;
                if (cells[{label, pred}] != '1)
                    cells[{label, pred}]++;
                r.cell_count = cells[{label, pred}];
            end
            r.correct_total = hits;
            position   = 0;
            lead_score = '0;
            lead_index = '0;
            due_results.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task compare_field(string field, logic [OUT_COUNT_W-1:0] seen,
                           logic [OUT_COUNT_W-1:0] want);
            if (seen !== want)
                report($sformatf("%s is %0h, expected %0h", field, seen, want));
        endtask

        task check_result(result_t seen);
            result_t want;
            if (due_results.size() == 0) begin
                report($sformatf("result word %h with nothing expected", seen));
                return;
            end
            want = due_results.pop_front();
            compare_field("is_readback", OUT_COUNT_W'(seen.is_readback),
                          OUT_COUNT_W'(want.is_readback));
            compare_field("chosen_class", OUT_COUNT_W'(seen.chosen_class),
                          OUT_COUNT_W'(want.chosen_class));
            compare_field("is_correct", OUT_COUNT_W'(seen.is_correct),
                          OUT_COUNT_W'(want.is_correct));
            compare_field("counted", OUT_COUNT_W'(seen.counted), OUT_COUNT_W'(want.counted));
            compare_field("cell_count", seen.cell_count, want.cell_count);
            compare_field("correct_total", seen.correct_total, want.correct_total);
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tuser;

    confusion_tracker tracker;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;
    int unsigned span_now;
    int unsigned cycle_count;

    int nc_plan     [PHASES] = '{10, 1, 16, 4, 0, 31, 3, 16};
    int size_plan   [PHASES] = '{10, 2, 16, 31, 1, 0, 16, 20};
    int idle_plan   [PHASES] = '{0, 55, 0, 20, 55, 0, 20, 0};
    int stall_plan  [PHASES] = '{0, 0, 55, 20, 0, 55, 20, 0};

    confusion_matrix_accumulator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver stalls at random, or holds off entirely while hold_left
    // counts down.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t seen;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.is_readback   = m_axis_tuser;
                seen.chosen_class  = m_axis_tdata[3:0];
                seen.is_correct    = m_axis_tdata[4];
                seen.counted       = m_axis_tdata[5];
                seen.cell_count    = m_axis_tdata[37:6];
                seen.correct_total = m_axis_tdata[69:38];
                tracker.check_result(seen);
            end
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_word(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[19:16],
                                  s_axis_tlast, s_axis_tdata[23:20], s_axis_tdata[27:24]);
        end
    end

    task write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task send_word(input logic req, input logic signed [SCORE_W-1:0] score,
                   input logic [LABEL_W-1:0] label, input logic last,
                   input logic [LABEL_W-1:0] row, input logic [LABEL_W-1:0] col);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {4'b0, col, row, label, score};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task send_score(input logic signed [SCORE_W-1:0] score, input logic [LABEL_W-1:0] label,
                    input logic last);
        send_word(REQ_SCORE, score, label, last, LABEL_W'($urandom), LABEL_W'($urandom));
    endtask

    task send_read(input logic [LABEL_W-1:0] row, input logic [LABEL_W-1:0] col);
        send_word(REQ_READ, SCORE_W'($urandom), LABEL_W'($urandom), 1'($urandom), row, col);
    endtask

    // Stops offering words, waits for every expected result, then lets the
    // pipeline settle so that no trailing score is still in flight.
    task drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [SCORE_W-1:0] pick_score();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return SCORE_W'(HALF_Q14 + $urandom_range(2) - 1);
            3:
            begin
                // A small pool of values makes ties common.
                case ($urandom_range(2))
                    0: return 16'sd0;
                    1: return 16'sd100;
                    default: return -16'sd100;
                endcase
            end
            default: return SCORE_W'($urandom);
        endcase
    endfunction

    function automatic logic [LABEL_W-1:0] pick_index();
        if (span_now > 0 && $urandom_range(99) < 75)
            return LABEL_W'($urandom_range(span_now - 1));
        return LABEL_W'($urandom_range(15));
    endfunction

    function automatic int pick_length(int classes);
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return $urandom_range(20, 17);
        if (classes >= 1 && classes <= CLASS_SLOTS && roll < 70)
            return classes;
        return $urandom_range(16, 1);
    endfunction

    task random_traffic(input int budget, input int classes);
        int                 sent;
        int                 length;
        logic [LABEL_W-1:0] label;
        logic               drop_last;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(99) < 12)
            begin
                send_read(pick_index(), pick_index());
                sent++;
            end
            else
            begin
                length    = pick_length(classes);
                label     = pick_index();
                drop_last = ($urandom_range(99) < 8);
                for (int k = 0; k < length; k++)
                begin
                    if ($urandom_range(99) < 8)
                    begin
                        send_read(pick_index(), pick_index());
                        sent++;
                    end
                    send_score(pick_score(), label, (k == length - 1) && !drop_last);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        tracker        = new();
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        span_now       = 10;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tuser   = 1'b0;
        s_axis_tlast   = 1'b0;
        s_axis_tdata   = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_SCORE_COUNT, CFG_DATA_W'(nc_plan[p]));
            write_reg(REG_MATRIX_SIZE, CFG_DATA_W'(size_plan[p]));
            span_now       = (size_plan[p] > CLASS_SLOTS) ? CLASS_SLOTS : size_plan[p];
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];

            if (p == 0)
            begin
                // Extreme scores, with a tie where the first maximum must win.
                send_score(16'sh8000, 4'd1, 1'b0);
                send_score(16'sh7fff, 4'd1, 1'b0);
                send_score(16'sh7fff, 4'd1, 1'b0);
                send_score(16'sd0, 4'd1, 1'b1);
                send_read(4'd1, 4'd1);
                send_read(4'd15, 4'd15);
                send_read(4'd0, 4'd10);
                // A read in the middle of a sample leaves the sample intact.
                send_score(16'sd5, 4'd3, 1'b0);
                send_read(4'd1, 4'd1);
                send_score(16'sd7, 4'd3, 1'b1);
                send_score(16'sd9, 4'd15, 1'b1);
                send_score(-16'sd1, 4'd0, 1'b1);
            end
            else if (p == 1)
            begin
                // Binary mode around the threshold, then a sample of several scores.
                send_score(HALF_Q14, 4'd0, 1'b1);
                send_score(HALF_Q14 + 16'sd1, 4'd1, 1'b1);
                send_score(16'sh8000, 4'd1, 1'b1);
                send_score(16'sh7fff, 4'd1, 1'b1);
                send_score(16'sd100, 4'd1, 1'b0);
                send_score(16'sd9000, 4'd1, 1'b0);
                send_score(16'sd50, 4'd1, 1'b1);
            end
            else if (p == 6)
            begin
                // The output is held off long enough for the unit to stop taking input.
                hold_left = 400;
                for (int k = 0; k < 10; k++)
                    send_read(pick_index(), pick_index());
            end

            random_traffic(RANDOM_ITEMS_PER_PHASE, nc_plan[p]);
            drain();
        end

        if (tracker.pending() != 0)
            tracker.report("expected results left over");
        if (tracker.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
